[rtl/bcanr_pkg.sv]
// Shared types and constants for the block checksum ACK/NAK receiver.
`timescale 1ns / 1ps
`default_nettype none

package bcanr_pkg;

  // Bytes gathered into one block before the end reply is sent.
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned BcW = $clog2(BLOCK_BYTES + 1);

  // Field widths.
  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 16;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 2;

  // Operation codes of an input request.
  localparam logic [OpW-1:0] OP_BYTE  = 2'd0;
  localparam logic [OpW-1:0] OP_IDLE  = 2'd1;
  localparam logic [OpW-1:0] OP_START = 2'd2;

  // Reply bytes.
  localparam logic [ByteW-1:0] REPLY_END = 8'h0A;
  localparam logic [ByteW-1:0] REPLY_ACK = 8'h06;
  localparam logic [ByteW-1:0] REPLY_NAK = 8'h15;

  // Counter saturation points.
  localparam logic [7:0]      CNT_MAX = 8'hFF;
  localparam logic [OffW-1:0] TOT_MAX = 16'hFFFF;

  // Status codes.
  localparam logic [StatW-1:0] ST_RUNNING  = 2'd0;
  localparam logic [StatW-1:0] ST_COMPLETE = 2'd1;
  localparam logic [StatW-1:0] ST_ERRLIM   = 2'd2;
  localparam logic [StatW-1:0] ST_TOLIM    = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_TRANSFER_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ERROR_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_LIMIT = 2'd2;

  // Configuration register reset values.
  localparam logic [15:0] RST_TRANSFER_SIZE = 16'd0;
  localparam logic [7:0]  RST_ERROR_LIMIT   = 8'd40;
  localparam logic [7:0]  RST_TIMEOUT_LIMIT = 8'd100;

  typedef struct packed {
    logic [15:0] transfer_size;
    logic [7:0]  error_limit;
    logic [7:0]  timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic             mem_write;
    logic [OffW-1:0]  mem_offset;
    logic [ByteW-1:0] mem_data;
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic [StatW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

[rtl/bcanr_engine.sv]
// Receiver state and the per-request update logic.
`timescale 1ns / 1ps
`default_nettype none

module bcanr_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [bcanr_pkg::OpW-1:0]    op_i,
  input  wire logic [bcanr_pkg::ByteW-1:0]  byte_i,
  input  wire bcanr_pkg::cfg_t              cfg_i,
  output bcanr_pkg::result_t                res_o
);

  logic                          awaiting_q, awaiting_d;
  logic [bcanr_pkg::BcW-1:0]     block_count_q, block_count_d;
  logic [7:0]                    running_sum_q, running_sum_d;
  logic [bcanr_pkg::OffW-1:0]    total_q, total_d;
  logic [7:0]                    error_count_q, error_count_d;
  logic [7:0]                    idle_count_q, idle_count_d;
  logic [bcanr_pkg::StatW-1:0]   finish_q, finish_d;

  // End check: only a running transfer can end, in priority order.
  function automatic logic [bcanr_pkg::StatW-1:0] end_check(
    input logic [bcanr_pkg::StatW-1:0] fc,
    input logic [bcanr_pkg::OffW-1:0]  tot,
    input logic [7:0]                  ec,
    input logic [7:0]                  ic,
    input bcanr_pkg::cfg_t             cfg
  );
    logic [bcanr_pkg::StatW-1:0] r;
    r = fc;
    if (fc == bcanr_pkg::ST_RUNNING) begin
      if (tot >= cfg.transfer_size) begin
        r = bcanr_pkg::ST_COMPLETE;
      end else if (ec >= cfg.error_limit) begin
        r = bcanr_pkg::ST_ERRLIM;
      end else if (ic >= cfg.timeout_limit) begin
        r = bcanr_pkg::ST_TOLIM;
      end
    end
    return r;
  endfunction

  // Next state and result for the request in the input register.
  always_comb begin
    logic [bcanr_pkg::OffW:0]   sum_w;
    logic [bcanr_pkg::BcW-1:0]  bc_inc;
    awaiting_d    = awaiting_q;
    block_count_d = block_count_q;
    running_sum_d = running_sum_q;
    total_d       = total_q;
    error_count_d = error_count_q;
    idle_count_d  = idle_count_q;
    finish_d      = finish_q;
    res_o         = '0;
    sum_w  = {1'b0, total_q} + {{(bcanr_pkg::OffW + 1 - bcanr_pkg::BcW){1'b0}}, block_count_q};
    bc_inc = block_count_q + 1'b1;

    case (op_i)
      bcanr_pkg::OP_START: begin
        awaiting_d    = 1'b0;
        block_count_d = '0;
        running_sum_d = '0;
        total_d       = '0;
        error_count_d = '0;
        idle_count_d  = '0;
        finish_d      = end_check(bcanr_pkg::ST_RUNNING, '0, '0, '0, cfg_i);
      end
      bcanr_pkg::OP_BYTE, bcanr_pkg::OP_IDLE: begin
        finish_d = end_check(finish_q, total_q, error_count_q, idle_count_q, cfg_i);
        if (finish_d == bcanr_pkg::ST_RUNNING) begin
          if (op_i == bcanr_pkg::OP_BYTE) begin
            if (awaiting_q) begin
              // Checksum byte: ACK commits the block, NAK retries it.
              res_o.tx_valid = 1'b1;
              if (byte_i == running_sum_q) begin
                total_d = sum_w[bcanr_pkg::OffW] ? bcanr_pkg::TOT_MAX
                                                 : sum_w[bcanr_pkg::OffW-1:0];
                res_o.tx_byte = bcanr_pkg::REPLY_ACK;
              end else begin
                if (error_count_q < bcanr_pkg::CNT_MAX) begin
                  error_count_d = error_count_q + 8'd1;
                end
                res_o.tx_byte = bcanr_pkg::REPLY_NAK;
              end
              awaiting_d    = 1'b0;
              block_count_d = '0;
              running_sum_d = '0;
            end else begin
              // Payload byte: store it and fold it into the checksum.
              res_o.mem_write  = 1'b1;
              res_o.mem_offset = sum_w[bcanr_pkg::OffW-1:0];
              res_o.mem_data   = byte_i;
              running_sum_d    = running_sum_q + byte_i;
              block_count_d    = bc_inc;
              if (bc_inc >= bcanr_pkg::BcW'(bcanr_pkg::BLOCK_BYTES)) begin
                awaiting_d     = 1'b1;
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = bcanr_pkg::REPLY_END;
              end
            end
          end else begin
            // Idle window: ends a partial block or counts a timeout.
            if (awaiting_q) begin
              if (idle_count_q < bcanr_pkg::CNT_MAX) begin
                idle_count_d = idle_count_q + 8'd1;
              end
            end else begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = bcanr_pkg::REPLY_END;
              if (block_count_q != '0) begin
                awaiting_d = 1'b1;
              end else if (idle_count_q < bcanr_pkg::CNT_MAX) begin
                idle_count_d = idle_count_q + 8'd1;
              end
            end
          end
          finish_d = end_check(finish_d, total_d, error_count_d, idle_count_d, cfg_i);
        end
      end
      default: begin
      end
    endcase
    res_o.status = finish_d;
  end

  // State registers, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q    <= 1'b0;
      block_count_q <= '0;
      running_sum_q <= '0;
      total_q       <= '0;
      error_count_q <= '0;
      idle_count_q  <= '0;
      finish_q      <= bcanr_pkg::ST_RUNNING;
    end else if (en_i) begin
      awaiting_q    <= awaiting_d;
      block_count_q <= block_count_d;
      running_sum_q <= running_sum_d;
      total_q       <= total_d;
      error_count_q <= error_count_d;
      idle_count_q  <= idle_count_d;
      finish_q      <= finish_d;
    end
  end

  // The block never grows past its size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_count_q <= bcanr_pkg::BcW'(bcanr_pkg::BLOCK_BYTES))
    else $error("block count beyond block size");

  // Waiting for a checksum means the block holds bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (block_count_q != '0))
    else $error("awaiting checksum with an empty block");

  // An ended transfer stays ended until a start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish_q != bcanr_pkg::ST_RUNNING && !(en_i && op_i == bcanr_pkg::OP_START))
    |=> $stable(finish_q))
    else $error("ended transfer changed status without a start");

  // An ended transfer neither stores bytes nor replies.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish_q != bcanr_pkg::ST_RUNNING) |-> (!res_o.mem_write && !res_o.tx_valid))
    else $error("activity after the transfer ended");

endmodule

`default_nettype wire

[rtl/block_checksum_ack_nak_receiver_unit.sv]
// Top level of the block checksum ACK/NAK receiver: stream ports, config, pipeline.
// Path: an accepted request is held in the input register and its result is
// registered in the output stage (two register stages, input and result).
// Throughput: one request per cycle; the state update is combinational logic in
// the engine, and the pipeline only stalls while the result register is held.
// Reset (rst_ni low, asynchronous): pipeline empty, counters cleared, status running,
// registers at transfer_size 0, error_limit 40, timeout_limit 100.
`timescale 1ns / 1ps
`default_nettype none

module block_checksum_ack_nak_receiver_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [bcanr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bcanr_pkg::CfgW-1:0]        cfg_wdata_i,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [bcanr_pkg::InDataW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  input  wire logic [bcanr_pkg::InUserW-1:0]     s_axis_tuser,  // [1:0] operation
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] mem_offset, [23:16] mem_data, [31:24] tx_byte, [33:32] status, rest zero
  output logic [bcanr_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic [bcanr_pkg::OutUserW-1:0]         m_axis_tuser   // [0] mem_write, [1] tx_valid
);

  bcanr_pkg::cfg_t                 cfg_q;
  logic                            in_valid_q;
  logic [bcanr_pkg::OpW-1:0]       in_op_q;
  logic [bcanr_pkg::ByteW-1:0]     in_byte_q;
  logic                            out_valid_q;
  bcanr_pkg::result_t              out_q;
  bcanr_pkg::result_t              res;
  logic                            out_free;
  logic                            advance;

  // Pipeline control: the result slot frees when empty or taken this cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.transfer_size <= bcanr_pkg::RST_TRANSFER_SIZE;
      cfg_q.error_limit   <= bcanr_pkg::RST_ERROR_LIMIT;
      cfg_q.timeout_limit <= bcanr_pkg::RST_TIMEOUT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bcanr_pkg::REG_TRANSFER_SIZE: cfg_q.transfer_size <= cfg_wdata_i;
        bcanr_pkg::REG_ERROR_LIMIT:   cfg_q.error_limit   <= cfg_wdata_i[7:0];
        bcanr_pkg::REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  bcanr_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .op_i   (in_op_q),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.status, out_q.tx_byte, out_q.mem_data, out_q.mem_offset};
  assign m_axis_tuser  = {out_q.tx_valid, out_q.mem_write};

endmodule

`default_nettype wire
